[hdl/pcs_pkg.sv]
// Shared types and constants for the configuration-space class scan sequencer.
package pcs_pkg;

   // Scan extent
   localparam int NUM_BUSES = 256;
   localparam int NUM_SLOTS = 32;
   localparam int NUM_FUNCS = 8;

   localparam logic [7:0] LAST_BUS  = 8'(NUM_BUSES - 1);
   localparam logic [4:0] LAST_SLOT = 5'(NUM_SLOTS - 1);
   localparam logic [2:0] LAST_FUNC = 3'(NUM_FUNCS - 1);

   // Configuration space dword offsets
   localparam logic [7:0] OFF_VENDOR = 8'h00;
   localparam logic [7:0] OFF_HEADER = 8'h0E & 8'hFC;
   localparam logic [7:0] OFF_CLASS  = 8'h08;

   localparam logic [15:0] VENDOR_ABSENT = 16'hFFFF;
   localparam logic [7:0]  IFACE_ANY     = 8'hFF;

   // Request command codes
   typedef enum logic {
      CMD_START = 1'b0,
      CMD_DATA  = 1'b1
   } cmd_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_FOUND = 2'd1,
      KIND_NONE  = 2'd2
   } kind_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_CLASS    = 2'd0,
      CSR_SUBCLASS = 2'd1,
      CSR_IFACE    = 2'd2
   } csr_index_type;

   // Scan phases
   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_VENDOR0 = 5'b00010,
      PH_HEADER  = 5'b00100,
      PH_VENDORF = 5'b01000,
      PH_CLASS   = 5'b10000
   } phase_type;

   // One result item
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  bus;
      logic [4:0]  slot;
      logic [2:0]  func_num;
      logic [7:0]  reg_offset;
      logic [31:0] config_address;
      logic [15:0] vendor_code;
      logic [15:0] device_code;
      logic [7:0]  found_class;
      logic [7:0]  found_subclass;
      logic [7:0]  found_interface;
   } rsp_type;

endpackage

[hdl/pci_class_scan_sequencer_core.sv]
// Configuration mechanism #1 scan sequencer that searches for a class code match.
// Each result is registered, in the skid register while the output register waits.
// Throughput: one request per cycle while the skid register is empty; next-request logic
//   is a few compares and counter increments between the state and output registers.
// A two-deep output stage (output register plus skid register) keeps req_tready high
//   while one result waits.
// Reset (synchronous, active high): scan idle, position zero, want_interface 255.
module pci_class_scan_sequencer_core
   import pcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] read_data
   input  logic         req_tuser,   // [0] command
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // bus, slot, func_num, reg_offset, config_address,
                                     // vendor_code, device_code, found_class,
                                     // found_subclass, found_interface
   output logic [1:0]   rsp_tuser,   // [1:0] kind
   // configuration writes
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   // Configuration registers
   logic [7:0] want_class_ff, want_subclass_ff, want_iface_ff;

   // Scan state
   phase_type  phase_ff, phase_in;
   logic [7:0] bus_ff, bus_in;
   logic [4:0] slot_ff, slot_in;
   logic [2:0] func_ff, func_in;
   logic       multi_ff, multi_in;
   logic [31:0] ids_ff, ids_in;

   // Output stage
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff;

   logic    req_fire, rsp_fire, push;
   rsp_type res;

   logic       slot_done, func_more, vendor_absent, class_match;
   logic [7:0] cc, sc, pi;

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_fire   = out_valid_ff && rsp_tready;

   assign rsp_tuser = out_ff.kind;
   assign rsp_tdata = {out_ff.found_interface, out_ff.found_subclass, out_ff.found_class,
                       out_ff.device_code, out_ff.vendor_code, out_ff.config_address,
                       out_ff.reg_offset, out_ff.func_num, out_ff.slot, out_ff.bus};

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         want_class_ff    <= '0;
         want_subclass_ff <= '0;
         want_iface_ff    <= IFACE_ANY;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CLASS:    want_class_ff    <= csr_wdata;
            CSR_SUBCLASS: want_subclass_ff <= csr_wdata;
            CSR_IFACE:    want_iface_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Decode the returned dword
   assign cc            = req_tdata[31:24];
   assign sc            = req_tdata[23:16];
   assign pi            = req_tdata[15:8];
   assign vendor_absent = (req_tdata[15:0] == VENDOR_ABSENT);
   assign class_match   = (cc == want_class_ff) && (sc == want_subclass_ff) &&
                          ((want_iface_ff == IFACE_ANY) || (pi == want_iface_ff));
   assign slot_done     = (slot_ff == LAST_SLOT) && (bus_ff == LAST_BUS);
   assign func_more     = multi_ff && (func_ff != LAST_FUNC);

   // Next scan state and result
   always_comb begin
      phase_type  ph;
      logic [7:0] b;
      logic [4:0] s;
      logic [2:0] f;
      logic [7:0] off;
      logic       emit_read, emit_none, next_slot, next_func;

      ph        = phase_ff;
      b         = bus_ff;
      s         = slot_ff;
      f         = func_ff;
      multi_in  = multi_ff;
      ids_in    = ids_ff;
      off       = OFF_VENDOR;
      emit_read = 1'b0;
      emit_none = 1'b0;
      next_slot = 1'b0;
      next_func = 1'b0;
      push      = 1'b0;
      res       = '0;

      if (cmd_type'(req_tuser) == CMD_START) begin
         // restart the scan at the first location
         b         = '0;
         s         = '0;
         f         = '0;
         multi_in  = 1'b0;
         ph        = PH_VENDOR0;
         emit_read = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_VENDOR0: begin
               if (vendor_absent) begin
                  next_slot = 1'b1;
               end else begin
                  ph        = PH_HEADER;
                  f         = '0;
                  off       = OFF_HEADER;
                  emit_read = 1'b1;
               end
            end
            PH_HEADER: begin
               multi_in  = req_tdata[23];
               f         = '0;
               ph        = PH_VENDORF;
               emit_read = 1'b1;
            end
            PH_VENDORF: begin
               if (vendor_absent) begin
                  next_func = 1'b1;
               end else begin
                  ids_in    = req_tdata;
                  ph        = PH_CLASS;
                  off       = OFF_CLASS;
                  emit_read = 1'b1;
               end
            end
            PH_CLASS: begin
               if (class_match) begin
                  ph                  = PH_IDLE;
                  push                = 1'b1;
                  res.kind            = KIND_FOUND;
                  res.bus             = bus_ff;
                  res.slot            = slot_ff;
                  res.func_num        = func_ff;
                  res.vendor_code     = ids_ff[15:0];
                  res.device_code     = ids_ff[31:16];
                  res.found_class     = cc;
                  res.found_subclass  = sc;
                  res.found_interface = pi;
               end else begin
                  next_func = 1'b1;
               end
            end
            default: ph = PH_IDLE;
         endcase
      end

      // advance to the next function, or fall through to the next slot
      if (next_func) begin
         if (func_more) begin
            f         = func_ff + 3'd1;
            ph        = PH_VENDORF;
            emit_read = 1'b1;
         end else begin
            next_slot = 1'b1;
         end
      end

      // advance to the next slot and bus, or finish
      if (next_slot) begin
         f        = '0;
         multi_in = 1'b0;
         if (slot_ff != LAST_SLOT) begin
            s         = slot_ff + 5'd1;
            ph        = PH_VENDOR0;
            emit_read = 1'b1;
         end else if (!slot_done) begin
            s         = '0;
            b         = bus_ff + 8'd1;
            ph        = PH_VENDOR0;
            emit_read = 1'b1;
         end else begin
            ph        = PH_IDLE;
            emit_none = 1'b1;
         end
      end

      if (emit_read) begin
         push               = 1'b1;
         res.kind           = KIND_READ;
         res.bus            = b;
         res.slot           = s;
         res.func_num       = f;
         res.reg_offset     = off;
         res.config_address = {1'b1, 7'd0, b, s, f, off};
      end
      if (emit_none) begin
         push     = 1'b1;
         res.kind = KIND_NONE;
      end

      phase_in = ph;
      bus_in   = b;
      slot_in  = s;
      func_in  = f;
   end

   // Hold scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bus_ff   <= '0;
         slot_ff  <= '0;
         func_ff  <= '0;
         multi_ff <= 1'b0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         bus_ff   <= bus_in;
         slot_ff  <= slot_in;
         func_ff  <= func_in;
         multi_ff <= multi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ids_ff <= ids_in;
      end
   end

   // Output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_fire && push) begin
         if (!out_valid_ff || rsp_fire) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_ff <= skid_ff;
         end
      end else if (req_fire && push) begin
         if (!out_valid_ff || rsp_fire) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

`ifndef SYNTHESIS
   // skid entry only fills behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register valid without output register");

   // a terminal result always ends the scan
   a_terminal_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && push && res.kind != KIND_READ) |=> phase_ff == PH_IDLE)
      else $error("scan not idle after final result");

   // only read requests carry an address, and it has the enable bit
   a_addr_by_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_READ) ? rsp_tdata[55] :
                      (rsp_tdata[55:16] == 40'd0)))
      else $error("config address does not match result kind");
`endif

endmodule
